FILE: hw/rtl/pcbt_pkg.sv
// Shared types and constants for the PC breakpoint table.
// No dependencies; compile first.
`default_nettype none

package pcbt_pkg;

    localparam int TABLE_ENTRIES_DEF = 128;

    localparam int PC_W   = 16;
    localparam int BANK_W = 8;
    localparam int KEY_W  = PC_W + BANK_W;

    typedef enum logic [1:0] {
        FN_CHECK  = 2'd0,
        FN_TOGGLE = 2'd1,
        FN_ARM    = 2'd2,
        FN_CLEAR  = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        TG_NONE    = 2'd0,
        TG_ADDED   = 2'd1,
        TG_REMOVED = 2'd2,
        TG_FULL    = 2'd3
    } t_tg;

    // controller -> datapath
    typedef struct packed {
        logic start;   // latch transaction, restart scan
        logic issue;   // issue table read at scan address
        logic finish;  // apply update, load result register
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        t_func op;
        logic  last_addr;
        logic  out_busy;
    } t_sts;

endpackage

`default_nettype wire

FILE: hw/rtl/pcbt_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`default_nettype none

module pcbt_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 128
) (
    input  wire logic                                      i_clk,
    input  wire logic                                      i_we,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0]  i_waddr,
    input  wire logic [WIDTH-1:0]                          i_wdata,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0]  i_raddr,
    output logic      [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

FILE: hw/rtl/pcbt_ctrl.sv
// Sequencer for the PC breakpoint table: accept, scan, drain, finish.
// Depends on pcbt_pkg.
`default_nettype none

module pcbt_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire pcbt_pkg::t_sts i_sts,
    output pcbt_pkg::t_cmd      o_cmd
);
    import pcbt_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_DRAIN  = 4'b0100,
        ST_FINISH = 4'b1000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state      = r_state;
        o_in_ready   = 1'b0;
        o_cmd.start  = 1'b0;
        o_cmd.issue  = 1'b0;
        o_cmd.finish = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    n_state     = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // arm and clear need no scan
                if (i_sts.op == FN_ARM || i_sts.op == FN_CLEAR) begin
                    n_state = ST_FINISH;
                end else begin
                    o_cmd.issue = 1'b1;
                    if (i_sts.last_addr) begin
                        n_state = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN: begin
                n_state = ST_FINISH;
            end
            ST_FINISH: begin
                if (!i_sts.out_busy) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/pcbt_dp.sv
// Datapath: entry RAM, active bits, one-shot entry, scan compare, result register.
// Depends on pcbt_pkg and pcbt_ram.
`default_nettype none

module pcbt_dp #(
    parameter int TABLE_ENTRIES = pcbt_pkg::TABLE_ENTRIES_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire pcbt_pkg::t_cmd              i_cmd,
    output pcbt_pkg::t_sts                   o_sts,
    input  wire logic [1:0]                  i_func,
    input  wire logic [pcbt_pkg::PC_W-1:0]   i_prog_counter,
    input  wire logic [pcbt_pkg::BANK_W-1:0] i_bank_number,
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output logic                             o_hit,
    output logic [1:0]                       o_toggle_result
);
    import pcbt_pkg::*;

    localparam int AW = $clog2(TABLE_ENTRIES > 1 ? TABLE_ENTRIES : 2);
    localparam logic [AW-1:0] LAST = AW'(TABLE_ENTRIES - 1);

    // latched transaction
    t_func            r_op;
    logic [KEY_W-1:0] r_key;

    // scan pipeline
    logic [AW-1:0]    r_rd_addr;
    logic [AW-1:0]    r_cmp_idx;
    logic             r_cmp_vld;
    logic             r_cmp_act;
    logic [KEY_W-1:0] w_rdata;

    logic             r_match_found;
    logic [AW-1:0]    r_match_idx;
    logic             r_free_found;
    logic [AW-1:0]    r_free_idx;

    logic [TABLE_ENTRIES-1:0] r_active;

    logic              r_os_act;
    logic [KEY_W-1:0]  r_os_key;

    logic             r_out_valid;
    logic             r_hit;
    t_tg              r_tg;

    logic w_we;
    logic w_os_eq;
    logic w_eq;

    assign w_we    = i_cmd.finish && r_op == FN_TOGGLE && !r_match_found && r_free_found;
    assign w_os_eq = r_os_act && r_os_key == r_key;
    assign w_eq    = r_cmp_vld && r_cmp_act && w_rdata == r_key;

    pcbt_ram #(
        .WIDTH (KEY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_free_idx),
        .i_wdata (r_key),
        .i_raddr (r_rd_addr),
        .o_rdata (w_rdata)
    );

    assign o_sts.op        = r_op;
    assign o_sts.last_addr = r_rd_addr == LAST;
    assign o_sts.out_busy  = r_out_valid && !i_out_ready;

    assign o_out_valid     = r_out_valid;
    assign o_hit           = r_hit;
    assign o_toggle_result = r_tg;

    // payload and scan state
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_op          <= t_func'(i_func);
            r_key         <= {i_prog_counter, i_bank_number};
            r_rd_addr     <= '0;
            r_match_found <= 1'b0;
            r_free_found  <= 1'b0;
        end else begin
            if (i_cmd.issue) begin
                r_rd_addr <= r_rd_addr + 1'b1;
            end
            if (w_eq && !r_match_found) begin
                r_match_found <= 1'b1;
                r_match_idx   <= r_cmp_idx;
            end
            if (r_cmp_vld && !r_cmp_act && !r_free_found) begin
                r_free_found <= 1'b1;
                r_free_idx   <= r_cmp_idx;
            end
        end
        r_cmp_idx <= r_rd_addr;
        r_cmp_act <= r_active[r_rd_addr];
        if (i_cmd.finish) begin
            r_hit <= r_op == FN_CHECK && (r_match_found || w_os_eq);
            case (r_op)
                FN_TOGGLE: begin
                    if (r_match_found) begin
                        r_tg <= TG_REMOVED;
                    end else if (r_free_found) begin
                        r_tg <= TG_ADDED;
                    end else begin
                        r_tg <= TG_FULL;
                    end
                end
                default: begin
                    r_tg <= TG_NONE;
                end
            endcase
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmp_vld   <= 1'b0;
            r_active    <= '0;
            r_os_act    <= 1'b0;
            r_os_key    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_cmp_vld <= i_cmd.issue;
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
                case (r_op)
                    FN_CHECK: begin
                        if (!r_match_found && w_os_eq) begin
                            r_os_act <= 1'b0;
                        end
                    end
                    FN_TOGGLE: begin
                        if (r_match_found) begin
                            r_active[r_match_idx] <= 1'b0;
                        end else if (r_free_found) begin
                            r_active[r_free_idx] <= 1'b1;
                        end
                    end
                    FN_ARM: begin
                        r_os_act <= 1'b1;
                        r_os_key <= r_key;
                    end
                    default: begin
                        r_active <= '0;
                    end
                endcase
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/pc_breakpoint_table.sv
// Top level of the PC breakpoint table: controller plus datapath.
// Depends on pcbt_pkg, pcbt_ctrl, pcbt_dp (and pcbt_ram below it).
`default_nettype none

//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+------------------------------------
//  in      | input     | i_in_valid / o_in_ready    | i_func, i_prog_counter, i_bank_number
//  out     | output    | o_out_valid / i_out_ready  | o_hit, o_toggle_result
//
// Check and toggle scan every entry of the entry RAM read port, one entry per
// cycle, then pass the drain state before finish; arm and clear go from the scan
// state straight to finish. One transaction is in work at a time; a new one is
// taken while the previous result still sits in the output register.
// Synchronous active-low reset clears the active bits and one-shot at once; the
// entry RAM is not cleared and is only ever read behind an active bit.
// A stalled output holds the finished transaction in its final state until taken.

module pc_breakpoint_table #(
    parameter int TABLE_ENTRIES = pcbt_pkg::TABLE_ENTRIES_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_ready,
    input  wire logic [1:0]                  i_func,
    input  wire logic [pcbt_pkg::PC_W-1:0]   i_prog_counter,
    input  wire logic [pcbt_pkg::BANK_W-1:0] i_bank_number,
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output logic                             o_hit,
    output logic [1:0]                       o_toggle_result
);
    import pcbt_pkg::*;

    t_cmd w_cmd;  // sequencing commands
    t_sts w_sts;  // op code, end of scan, output stall

    pcbt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    pcbt_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_func          (i_func),
        .i_prog_counter  (i_prog_counter),
        .i_bank_number   (i_bank_number),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_hit           (o_hit),
        .o_toggle_result (o_toggle_result)
    );

endmodule

`default_nettype wire
